>>> rtl/core/mmd_pkg.sv
// ----------------------------------------------------------------------------
// mmd_pkg
// Types and address constants for the memory map decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mmd_pkg;

  typedef enum logic [3:0] {
    TGT_CONST    = 4'd0,
    TGT_MAIN     = 4'd1,
    TGT_DISK_ROM = 4'd2,
    TGT_DISK_RAM = 4'd3,
    TGT_PAGED    = 4'd4,
    TGT_FDC      = 4'd5,
    TGT_VIA1     = 4'd6,
    TGT_SERIAL   = 4'd7,
    TGT_VIA2     = 4'd8,
    TGT_RTC      = 4'd9,
    TGT_KEYBOARD = 4'd10,
    TGT_NONE     = 4'd11
  } target_t;

  typedef struct packed {
    target_t     target;
    logic [15:0] location;
    logic [3:0]  bank;
    logic [7:0]  constant_data;
    logic        write_strobe;
    logic        attr_write;
    logic        attr_value;
    logic        keyboard_ack;
  } result_t;

  // bus commands
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;

  // configuration register indexes
  localparam logic [2:0] REG_EXPANSION = 3'd0;
  localparam logic [2:0] REG_ROM_KB    = 3'd1;
  localparam logic [2:0] REG_BASIC     = 3'd2;
  localparam logic [2:0] REG_BASIC_END = 3'd3;
  localparam logic [2:0] REG_DISK      = 3'd4;
  localparam logic [2:0] REG_PAGES     = 3'd5;
  localparam logic [2:0] REG_VIDEO_KBD = 3'd6;
  localparam logic [2:0] REG_SERIAL    = 3'd7;

  // address map
  localparam logic [15:0] MASK_1K      = 16'h03FF;
  localparam logic [15:0] RAM_TOP      = 16'h2000;
  localparam logic [15:0] ATTR_BASE    = 16'h0200;
  localparam logic [15:0] ATTR_TOP     = 16'h03FF;
  localparam logic [15:0] FOLD_RAM_TOP = 16'h8000;
  localparam logic [15:0] DROM_BASE    = 16'hA800;
  localparam logic [15:0] DRAM_BASE    = 16'hB800;
  localparam logic [15:0] IO_BASE      = 16'hBC00;
  localparam logic [15:0] IO_RTC       = 16'hBC40;
  localparam logic [15:0] IO_FDC       = 16'hBF90;
  localparam logic [15:0] IO_VIA1      = 16'hBFC0;
  localparam logic [15:0] IO_SERIAL    = 16'hBFD0;
  localparam logic [15:0] IO_VIA2      = 16'hBFE0;
  localparam logic [15:0] IO_SYS       = 16'hBFF0;
  localparam logic [15:0] IO_GFX_CLR   = 16'hBFF2;
  localparam logic [15:0] IO_KBD       = 16'hBFF3;
  localparam logic [15:0] BASIC_BASE   = 16'hC000;
  localparam logic [15:0] WR_OFF_BASE  = 16'hE800;
  localparam logic [15:0] BANK_REG     = 16'hFFF0;
  localparam logic [11:0] DROM_SWAP    = 12'h800;

endpackage

`default_nettype wire

>>> rtl/core/memory_map_decoder_top.sv
// ----------------------------------------------------------------------------
// memory_map_decoder_top
// Decodes one bus access per word into target, location and side effects,
// with base-unit mirroring, paged RAM and the graphics/bank registers.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in_       input      in_valid/in_stall    cmd, address, write_data
//  out_      output     out_valid/out_stall  target, location, bank, ...
//  cfg       input      psel/penable/pwrite  paddr, pwdata, prdata
//
//  the result word is registered at the edge that accepts the input word
//  a new word is taken every cycle unless the result register is stalled
//  bank and graphics registers update at the edge that accepts the word,
//  so the next word sees them
//  reset clears the result valid, state and loads register defaults
// ----------------------------------------------------------------------------
`default_nettype none

module memory_map_decoder_top (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            in_cmd,
  input  wire logic [15:0]           in_address,
  input  wire logic [7:0]            in_write_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [3:0]                 out_target,
  output logic [15:0]                out_location,
  output logic [3:0]                 out_bank,
  output logic [7:0]                 out_constant_data,
  output logic                       out_write_strobe,
  output logic                       out_attr_write,
  output logic                       out_attr_value,
  output logic                       out_keyboard_ack,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [4:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import mmd_pkg::*;

  logic        expansion_r;
  logic [2:0]  rom_kb_r;
  logic        basic_r;
  logic [15:0] basic_end_r;
  logic        disk_r;
  logic [4:0]  pages_r;
  logic        video_kbd_r;
  logic        serial_r;

  logic        gfx_r, gfx_nxt;
  logic [7:0]  bank_r, bank_nxt;
  result_t     res_r, res_nxt;
  logic        out_valid_r;

  logic        accept;
  logic        cfg_wr;
  logic [2:0]  reg_idx;

  logic [15:0] ra, wa;
  logic        wdrop, dbg, rom_hit;
  logic [15:0] drom_off, dram_off;
  logic [15:0] wdram_off;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign pready   = 1'b1;
  assign reg_idx  = paddr[4:2];
  assign cfg_wr   = psel & penable & pwrite;

  always_comb begin
    unique case (reg_idx)
      REG_EXPANSION: prdata = {31'b0, expansion_r};
      REG_ROM_KB:    prdata = {29'b0, rom_kb_r};
      REG_BASIC:     prdata = {31'b0, basic_r};
      REG_BASIC_END: prdata = {16'b0, basic_end_r};
      REG_DISK:      prdata = {31'b0, disk_r};
      REG_PAGES:     prdata = {27'b0, pages_r};
      REG_VIDEO_KBD: prdata = {31'b0, video_kbd_r};
      REG_SERIAL:    prdata = {31'b0, serial_r};
      default:       prdata = '0;
    endcase
  end

  // address folding
  always_comb begin
    ra    = in_address;
    wa    = in_address;
    wdrop = 1'b0;
    if (!expansion_r) begin
      if (in_address <= FOLD_RAM_TOP) begin
        ra = in_address & MASK_1K;
      end else if (in_address <= BASIC_BASE) begin
        ra = {IO_SYS[15:4], in_address[3:0]};
      end else if (rom_kb_r == 3'd1) begin
        ra = {6'b111111, in_address[9:0]};
      end else begin
        ra = {5'b11111, in_address[10:0]};
      end
      if (in_address < IO_BASE) begin
        wa = in_address & MASK_1K;
      end else if (in_address <= BASIC_BASE) begin
        wa = {IO_SYS[15:4], in_address[3:0]};
      end else begin
        wdrop = 1'b1;
      end
    end
  end

  assign dbg       = (in_cmd != CMD_READ);
  assign rom_hit   = ({1'b0, ra[15:10]} + {4'b0, rom_kb_r}) >= 7'd64;
  assign drom_off  = ra - DROM_BASE;
  assign dram_off  = ra - DRAM_BASE;
  assign wdram_off = wa - DRAM_BASE;

  always_comb begin
    res_nxt = '{target: TGT_NONE, location: 16'h0, bank: 4'h0, constant_data: 8'h00,
                write_strobe: 1'b0, attr_write: 1'b0, attr_value: 1'b0,
                keyboard_ack: 1'b0};
    gfx_nxt  = gfx_r;
    bank_nxt = bank_r;
    if (in_cmd == CMD_WRITE) begin
      priority if (wdrop) begin
        res_nxt.target = TGT_NONE;
      end else if (wa <= RAM_TOP) begin
        res_nxt.target       = TGT_MAIN;
        res_nxt.location     = wa;
        res_nxt.write_strobe = 1'b1;
        if (wa >= ATTR_BASE && wa <= ATTR_TOP) begin
          res_nxt.attr_write = 1'b1;
          res_nxt.attr_value = gfx_r;
        end
      end else if (basic_r && wa >= BASIC_BASE && wa < basic_end_r) begin
        res_nxt.target = TGT_NONE;
      end else if (wa >= WR_OFF_BASE) begin
        if (wa >= BANK_REG) bank_nxt = in_write_data;
      end else if (disk_r && wa >= DROM_BASE && wa < DRAM_BASE) begin
        res_nxt.target = TGT_NONE;
      end else if (disk_r && wa >= DRAM_BASE && wa < IO_BASE) begin
        res_nxt.target       = TGT_DISK_RAM;
        res_nxt.location     = {6'b0, wdram_off[9:0]};
        res_nxt.write_strobe = 1'b1;
      end else if (disk_r && wa[15:4] == IO_FDC[15:4]) begin
        res_nxt.target       = TGT_FDC;
        res_nxt.location     = {12'b0, wa[3:0]};
        res_nxt.write_strobe = 1'b1;
      end else if (wa[15:4] == IO_VIA1[15:4]) begin
        res_nxt.target       = TGT_VIA1;
        res_nxt.location     = {12'b0, wa[3:0]};
        res_nxt.write_strobe = 1'b1;
      end else if (wa[15:4] == IO_SERIAL[15:4]) begin
        if (serial_r) begin
          res_nxt.target       = TGT_SERIAL;
          res_nxt.location     = {14'b0, wa[1:0]};
          res_nxt.write_strobe = 1'b1;
        end
      end else if (wa[15:4] == IO_RTC[15:4]) begin
        res_nxt.target       = TGT_RTC;
        res_nxt.location     = {12'b0, wa[3:0]};
        res_nxt.write_strobe = 1'b1;
      end else if (wa[15:4] == IO_VIA2[15:4]) begin
        res_nxt.target       = TGT_VIA2;
        res_nxt.location     = {12'b0, wa[3:0]};
        res_nxt.write_strobe = 1'b1;
      end else if (wa == IO_SYS) begin
        res_nxt.keyboard_ack = video_kbd_r;
      end else begin
        if (wa == IO_GFX_CLR || wa == IO_KBD) gfx_nxt = 1'b0;
        if ((wa < IO_BASE || wa >= BASIC_BASE) && ({1'b0, bank_r[3:0]} < pages_r)) begin
          res_nxt.target       = TGT_PAGED;
          res_nxt.location     = wa;
          res_nxt.bank         = bank_r[3:0];
          res_nxt.write_strobe = 1'b1;
        end
      end
    end else begin
      priority if (ra <= RAM_TOP) begin
        res_nxt.target   = TGT_MAIN;
        res_nxt.location = ra;
      end else if (basic_r && ra >= BASIC_BASE && ra < basic_end_r) begin
        res_nxt.target   = TGT_MAIN;
        res_nxt.location = ra;
      end else if (disk_r && ra >= DROM_BASE && ra < DRAM_BASE) begin
        res_nxt.target   = TGT_DISK_ROM;
        res_nxt.location = {4'b0, drom_off[11:0] ^ DROM_SWAP};
      end else if (disk_r && ra >= DRAM_BASE && ra < IO_BASE) begin
        res_nxt.target   = TGT_DISK_RAM;
        res_nxt.location = {6'b0, dram_off[9:0]};
      end else if (rom_hit) begin
        res_nxt.target   = TGT_MAIN;
        res_nxt.location = ra;
      end else if (ra >= IO_BASE && ra < BASIC_BASE) begin
        res_nxt.target        = TGT_CONST;
        res_nxt.constant_data = 8'hFF;
        priority if (dbg) begin
          res_nxt.target = TGT_CONST;
        end else if (disk_r && ra[15:4] == IO_FDC[15:4]) begin
          res_nxt.target        = TGT_FDC;
          res_nxt.constant_data = 8'h00;
          res_nxt.location      = {12'b0, ra[3:0]};
        end else if (ra[15:4] == IO_VIA1[15:4]) begin
          res_nxt.target        = TGT_VIA1;
          res_nxt.constant_data = 8'h00;
          res_nxt.location      = {12'b0, ra[3:0]};
        end else if (serial_r && ra[15:4] == IO_SERIAL[15:4]) begin
          res_nxt.target        = TGT_SERIAL;
          res_nxt.constant_data = 8'h00;
          res_nxt.location      = {14'b0, ra[1:0]};
        end else if (ra[15:4] == IO_VIA2[15:4]) begin
          res_nxt.target        = TGT_VIA2;
          res_nxt.constant_data = 8'h00;
          res_nxt.location      = {12'b0, ra[3:0]};
        end else if (ra[15:4] == IO_RTC[15:4]) begin
          res_nxt.target        = TGT_RTC;
          res_nxt.constant_data = 8'h00;
          res_nxt.location      = {12'b0, ra[3:0]};
        end else begin
          if (ra == IO_SYS) gfx_nxt = 1'b1;
          if (ra == IO_KBD) begin
            res_nxt.constant_data = 8'h00;
            if (video_kbd_r) begin
              res_nxt.target   = TGT_KEYBOARD;
              res_nxt.location = 16'd3;
            end
          end
        end
      end else if ({1'b0, bank_r[7:4]} < pages_r) begin
        res_nxt.target   = TGT_PAGED;
        res_nxt.location = ra;
        res_nxt.bank     = bank_r[7:4];
      end else begin
        res_nxt.target        = TGT_CONST;
        res_nxt.constant_data = 8'hFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expansion_r <= 1'b0;
      rom_kb_r    <= 3'd1;
      basic_r     <= 1'b0;
      basic_end_r <= BASIC_BASE;
      disk_r      <= 1'b0;
      pages_r     <= 5'd0;
      video_kbd_r <= 1'b1;
      serial_r    <= 1'b0;
      gfx_r       <= 1'b0;
      bank_r      <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (reg_idx)
          REG_EXPANSION: expansion_r <= pwdata[0];
          REG_ROM_KB:    rom_kb_r    <= pwdata[2:0];
          REG_BASIC:     basic_r     <= pwdata[0];
          REG_BASIC_END: basic_end_r <= pwdata[15:0];
          REG_DISK:      disk_r      <= pwdata[0];
          REG_PAGES:     pages_r     <= pwdata[4:0];
          REG_VIDEO_KBD: video_kbd_r <= pwdata[0];
          REG_SERIAL:    serial_r    <= pwdata[0];
          default:       ;
        endcase
      end
      if (accept) begin
        gfx_r  <= gfx_nxt;
        bank_r <= bank_nxt;
      end
      if (!out_stall || !out_valid_r) begin
        out_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_target        = res_r.target;
  assign out_location      = res_r.location;
  assign out_bank          = res_r.bank;
  assign out_constant_data = res_r.constant_data;
  assign out_write_strobe  = res_r.write_strobe;
  assign out_attr_write    = res_r.attr_write;
  assign out_attr_value    = res_r.attr_value;
  assign out_keyboard_ack  = res_r.keyboard_ack;

endmodule

`default_nettype wire
